// ===== hdl/wdte_pkg.sv =====
// Shared constants for the word delta transform encoder.
package wdte_pkg;

   localparam int HISTORY_DEPTH_DEF = 64;
   localparam int FIT_WINDOW_DEF    = 64;

   localparam int WORD_WIDTH      = 32;
   localparam int MODE_WIDTH      = 2;
   localparam int STRIDE_WIDTH    = 7;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 7;

   localparam logic [MODE_WIDTH-1:0] MODE_RAW    = 2'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_FIRST  = 2'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_RESID  = 2'd2;
   localparam logic [MODE_WIDTH-1:0] MODE_STRIDE = 2'd3;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MODE   = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STRIDE = 1'd1;

   localparam logic [STRIDE_WIDTH-1:0] STRIDE_RESET = 7'd1;

endpackage

// ===== hdl/word_delta_transform_encoder_top.sv =====
// Word delta transform encoder: history ring, sequencer and shift-subtract divider.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   req_block_start, req_word_in
//   rsp      out        rsp_valid/rsp_stall   rsp_word_out
//   csr      in         csr_valid/csr_ready   csr_index, csr_wdata
//
// Raw mode, or a word with no history to use: straight from idle to the output load.
// First and stride difference: ring read, subtract, output load.
// Residual mode: ring read, the 32-step shift-subtract divider, one multiply
// and one subtract, then the output load. Synchronous active-high reset
// clears control state; the ring holds no reset value. A stalled result
// waits in the output register and the next transaction is taken meanwhile.
module word_delta_transform_encoder_top #(
   parameter int HISTORY_DEPTH = wdte_pkg::HISTORY_DEPTH_DEF,
   parameter int FIT_WINDOW    = wdte_pkg::FIT_WINDOW_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_block_start,
   input  logic [wdte_pkg::WORD_WIDTH-1:0]        req_word_in,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [wdte_pkg::WORD_WIDTH-1:0]        rsp_word_out,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [wdte_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [wdte_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);

   localparam int WW   = wdte_pkg::WORD_WIDTH;
   localparam int PW   = $clog2(HISTORY_DEPTH);
   localparam int DW   = $clog2(HISTORY_DEPTH + 1);
   localparam int AW   = $clog2(2 * HISTORY_DEPTH);
   localparam int SW   = wdte_pkg::STRIDE_WIDTH;
   localparam int CW   = (DW > SW) ? DW : SW;
   localparam int KMAX = (FIT_WINDOW - 1 < HISTORY_DEPTH) ? FIT_WINDOW - 1 : HISTORY_DEPTH;
   localparam int NW   = $clog2(WW);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_READ = 3'd1;
   localparam logic [2:0] S_CALC = 3'd2;
   localparam logic [2:0] S_DIV  = 3'd3;
   localparam logic [2:0] S_MUL  = 3'd4;
   localparam logic [2:0] S_SUB  = 3'd5;
   localparam logic [2:0] S_DONE = 3'd6;

   logic [WW-1:0] ring [HISTORY_DEPTH];

   logic [2:0]   state_ff, state_in;
   logic [wdte_pkg::MODE_WIDTH-1:0] mode_ff, mode_in;
   logic [SW-1:0] stride_ff, stride_in;
   logic [PW-1:0] ptr_ff, ptr_in;
   logic [DW-1:0] fill_ff, fill_in;
   logic [WW-1:0] idx_ff, idx_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [WW-1:0] rsp_word_ff, rsp_word_in;
   logic [WW-1:0] word_ff, word_in;
   logic [DW-1:0] dist_ff, dist_in;
   logic [WW-1:0] past_ff;
   logic [WW-1:0] res_ff, res_in;
   logic [WW-1:0] dq_ff, dq_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic          neg_ff, neg_in;
   logic [NW-1:0] cnt_ff, cnt_in;

   logic          accept;
   logic          out_free;
   logic [DW-1:0] fill_eff;
   logic [WW-1:0] idx_eff;
   logic [CW-1:0] stride_c;
   logic [CW-1:0] period_c;
   logic [DW-1:0] period;
   logic [DW-1:0] fit_k;
   logic [AW-1:0] addr_sum;
   logic [PW-1:0] rd_addr;
   logic [WW:0]   diff;
   logic [WW-1:0] mag;
   logic [DW:0]   rem_sh;
   logic [WW-1:0] sigma;
   logic [WW-1:0] mul_full;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_word_out = rsp_word_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign fill_eff = req_block_start ? '0 : fill_ff;
   assign idx_eff  = req_block_start ? '0 : idx_ff;

   always_comb begin
      stride_c = CW'(stride_ff);
      if (stride_c == '0) begin
         period_c = CW'(1);
      end else if (stride_c > CW'(HISTORY_DEPTH)) begin
         period_c = CW'(HISTORY_DEPTH);
      end else begin
         period_c = stride_c;
      end
      period = DW'(period_c);
      fit_k  = (fill_eff > DW'(KMAX)) ? DW'(KMAX) : fill_eff;
   end

   always_comb begin
      addr_sum = AW'(ptr_ff) + AW'(HISTORY_DEPTH) - AW'(dist_ff);
      if (addr_sum >= AW'(HISTORY_DEPTH)) begin
         rd_addr = PW'(addr_sum - AW'(HISTORY_DEPTH));
      end else begin
         rd_addr = PW'(addr_sum);
      end
   end

   assign diff     = {1'b0, word_ff} - {1'b0, past_ff};
   assign mag      = diff[WW] ? WW'(-diff) : diff[WW-1:0];
   assign rem_sh   = {rem_ff, dq_ff[WW-1]};
   assign sigma    = neg_ff ? -dq_ff : dq_ff;
   assign mul_full = sigma * idx_ff;

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      stride_in    = stride_ff;
      ptr_in       = ptr_ff;
      fill_in      = fill_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;
      word_in      = word_ff;
      dist_in      = dist_ff;
      res_in       = res_ff;
      dq_in        = dq_ff;
      rem_in       = rem_ff;
      neg_in       = neg_ff;
      cnt_in       = cnt_ff;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            wdte_pkg::CSR_MODE:   mode_in   = csr_wdata[wdte_pkg::MODE_WIDTH-1:0];
            wdte_pkg::CSR_STRIDE: stride_in = csr_wdata[SW-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               word_in  = req_word_in;
               res_in   = req_word_in;
               fill_in  = fill_eff;
               idx_in   = idx_eff;
               state_in = S_DONE;
               case (mode_ff)
                  wdte_pkg::MODE_FIRST: begin
                     dist_in = DW'(1);
                     if (fill_eff != '0) state_in = S_READ;
                  end
                  wdte_pkg::MODE_RESID: begin
                     dist_in = fit_k;
                     if (fit_k != '0) state_in = S_READ;
                  end
                  wdte_pkg::MODE_STRIDE: begin
                     dist_in = period;
                     if (fill_eff >= period) state_in = S_READ;
                  end
                  default: ;
               endcase
            end
         end
         S_READ: begin
            state_in = S_CALC;
         end
         S_CALC: begin
            if (mode_ff == wdte_pkg::MODE_RESID) begin
               neg_in   = diff[WW];
               dq_in    = mag;
               rem_in   = '0;
               cnt_in   = NW'(WW - 1);
               state_in = S_DIV;
            end else begin
               res_in   = word_ff - past_ff;
               state_in = S_DONE;
            end
         end
         S_DIV: begin
            if (rem_sh >= {1'b0, dist_ff}) begin
               rem_in = DW'(rem_sh - {1'b0, dist_ff});
               dq_in  = {dq_ff[WW-2:0], 1'b1};
            end else begin
               rem_in = rem_sh[DW-1:0];
               dq_in  = {dq_ff[WW-2:0], 1'b0};
            end
            cnt_in = cnt_ff - NW'(1);
            if (cnt_ff == '0) state_in = S_MUL;
         end
         S_MUL: begin
            res_in   = mul_full;
            state_in = S_SUB;
         end
         S_SUB: begin
            res_in   = word_ff - res_ff;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = res_ff;
               ptr_in       = (ptr_ff == PW'(HISTORY_DEPTH - 1)) ? '0 : ptr_ff + PW'(1);
               idx_in       = idx_ff + WW'(1);
               if (fill_ff < DW'(HISTORY_DEPTH)) fill_in = fill_ff + DW'(1);
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= wdte_pkg::MODE_RAW;
         stride_ff    <= wdte_pkg::STRIDE_RESET;
         ptr_ff       <= '0;
         fill_ff      <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         stride_ff    <= stride_in;
         ptr_ff       <= ptr_in;
         fill_ff      <= fill_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
      word_ff     <= word_in;
      dist_ff     <= dist_in;
      res_ff      <= res_in;
      dq_ff       <= dq_in;
      rem_ff      <= rem_in;
      neg_ff      <= neg_in;
      cnt_ff      <= cnt_in;
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_READ) begin
         past_ff <= ring[rd_addr];
      end
      if ((state_ff == S_DONE) && out_free) begin
         ring[ptr_ff] <= word_ff;
      end
   end

endmodule

// ===== bench/word_delta_transform_encoder_top_tb.sv =====
// Self-checking testbench for the word delta transform encoder: directed table, then random blocks.
`timescale 1ns / 1ps

module word_delta_transform_encoder_top_tb;

   typedef enum bit {ROW_CFG, ROW_WORD} row_kind_type;

   typedef struct {
      row_kind_type                           kind;
      logic [wdte_pkg::MODE_WIDTH-1:0]        mode;
      logic [wdte_pkg::STRIDE_WIDTH-1:0]      stride;
      bit                                     bs;
      logic [wdte_pkg::WORD_WIDTH-1:0]        word;
      bit                                     known;
      logic [wdte_pkg::WORD_WIDTH-1:0]        result;
   } stim_row_type;

   logic                                   clock = 1'b0;
   logic                                   reset = 1'b1;
   logic                                   req_valid = 1'b0;
   logic                                   req_stall;
   logic                                   req_block_start = 1'b0;
   logic [wdte_pkg::WORD_WIDTH-1:0]        req_word_in = '0;
   logic                                   rsp_valid;
   logic                                   rsp_stall = 1'b0;
   logic [wdte_pkg::WORD_WIDTH-1:0]        rsp_word_out;
   logic                                   csr_valid = 1'b0;
   logic                                   csr_ready;
   logic [wdte_pkg::CSR_INDEX_WIDTH-1:0]   csr_index = '0;
   logic [wdte_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata = '0;

   // predictor state
   logic [wdte_pkg::WORD_WIDTH-1:0]        hist [0:63];
   logic [5:0]                             hist_ptr = '0;
   logic [wdte_pkg::WORD_WIDTH-1:0]        word_idx = '0;
   logic [6:0]                             fill = '0;
   logic [wdte_pkg::MODE_WIDTH-1:0]        cur_mode = wdte_pkg::MODE_RAW;
   logic [wdte_pkg::STRIDE_WIDTH-1:0]      cur_stride = wdte_pkg::STRIDE_RESET;

   logic [wdte_pkg::WORD_WIDTH-1:0]        pending_words [$];
   logic [wdte_pkg::WORD_WIDTH-1:0]        oldest_word;
   stim_row_type                           dir_rows [$];
   int                                     failures = 0;
   int                                     accepted_count = 0;
   bit                                     quiet = 1'b0;
   bit                                     hold_go = 1'b0;
   int                                     hold_left = 0;

   word_delta_transform_encoder_top i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_block_start (req_block_start),
      .req_word_in     (req_word_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_word_out    (rsp_word_out),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #4ms;
      $display("TEST FAILED");
      $finish;
   end

   function automatic void add_cfg_row(logic [wdte_pkg::MODE_WIDTH-1:0] mode,
                                       logic [wdte_pkg::STRIDE_WIDTH-1:0] stride);
      stim_row_type row;
      row = '{ROW_CFG, mode, stride, 1'b0, '0, 1'b0, '0};
      dir_rows.insert(dir_rows.size(), row);
   endfunction

   function automatic void add_word_row(bit bs, logic [wdte_pkg::WORD_WIDTH-1:0] w, bit known,
                                        logic [wdte_pkg::WORD_WIDTH-1:0] result);
      stim_row_type row;
      row = '{ROW_WORD, wdte_pkg::MODE_RAW, '0, bs, w, known, result};
      dir_rows.insert(dir_rows.size(), row);
   endfunction

   function automatic logic [wdte_pkg::WORD_WIDTH-1:0] predict_transform(
      bit bs, logic [wdte_pkg::WORD_WIDTH-1:0] w);
      logic [wdte_pkg::WORD_WIDTH-1:0] r;
      logic [6:0]            gap;
      logic [5:0]            slot;
      longint                diff;
      longint                sigma;
      r = w;
      if (bs) begin
         word_idx = '0;
         fill = '0;
      end
      case (cur_mode)
         wdte_pkg::MODE_FIRST: begin
            if (fill >= 7'd1) r = w - hist[hist_ptr - 6'd1];
         end
         wdte_pkg::MODE_RESID: begin
            gap = (fill > 7'd63) ? 7'd63 : fill;
            if (gap != 7'd0) begin
               slot = hist_ptr - gap[5:0];
               diff = longint'(w) - longint'(hist[slot]);
               sigma = diff / longint'(gap);
               r = w - 32'(sigma * longint'(word_idx));
            end
         end
         wdte_pkg::MODE_STRIDE: begin
            gap = cur_stride;
            if (gap == 7'd0) gap = 7'd1;
            if (gap > 7'd64) gap = 7'd64;
            slot = hist_ptr - gap[5:0];
            if (fill >= gap) r = w - hist[slot];
         end
         default: ;
      endcase
      hist[hist_ptr] = w;
      hist_ptr = hist_ptr + 6'd1;
      word_idx = word_idx + 32'd1;
      if (fill < 7'd64) fill = fill + 7'd1;
      return r;
   endfunction

   task automatic send_word(bit bs, logic [wdte_pkg::WORD_WIDTH-1:0] w, bit known,
                            logic [wdte_pkg::WORD_WIDTH-1:0] result);
      logic [wdte_pkg::WORD_WIDTH-1:0] pred;
      while (!quiet && $urandom_range(99) < 18) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_block_start <= bs;
      req_word_in <= w;
      do @(posedge clock); while (req_stall !== 1'b0);
      pred = predict_transform(bs, w);
      pending_words.insert(pending_words.size(), known ? result : pred);
      accepted_count++;
      quiet = (accepted_count >= 170 && accepted_count < 320);
      @(negedge clock);
   endtask

   task automatic write_reg(logic [wdte_pkg::CSR_INDEX_WIDTH-1:0] idx,
                            logic [wdte_pkg::CSR_DATA_WIDTH-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (csr_ready !== 1'b1);
      if (idx == wdte_pkg::CSR_MODE)
         cur_mode = val[wdte_pkg::MODE_WIDTH-1:0];
      else
         cur_stride = val;
      @(negedge clock);
   endtask

   task automatic write_regs(logic [wdte_pkg::MODE_WIDTH-1:0] mode,
                             logic [wdte_pkg::STRIDE_WIDTH-1:0] stride);
      write_reg(wdte_pkg::CSR_MODE, wdte_pkg::CSR_DATA_WIDTH'(mode));
      write_reg(wdte_pkg::CSR_STRIDE, stride);
      csr_valid <= 1'b0;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_words.size() != 0);
   endtask

   // receiver: random stalls, plus one long hold-off
   always @(negedge clock) begin
      if (hold_go) begin
         hold_go = 1'b0;
         hold_left = 400;
      end
      if (hold_left != 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !quiet && ($urandom_range(99) < 18);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_words.size() == 0) begin
            $display("%0t: unexpected word_out, expected none, actual %08h",
                     $time, rsp_word_out);
            failures++;
         end else begin
            oldest_word = pending_words.pop_front();
            if (rsp_word_out !== oldest_word) begin
               $display("%0t: word_out mismatch, expected %08h, actual %08h",
                        $time, oldest_word, rsp_word_out);
               failures++;
            end
         end
      end
   end

   initial begin
      int                                  issued;
      int                                  phase_len;
      int                                  n;
      int                                  blk;
      int                                  style;
      bit                                  bs;
      bit                                  hold_used;
      logic [wdte_pkg::WORD_WIDTH-1:0]     base;
      logic [wdte_pkg::WORD_WIDTH-1:0]     slope;
      logic [wdte_pkg::WORD_WIDTH-1:0]     w;
      logic [wdte_pkg::MODE_WIDTH-1:0]     m;
      logic [wdte_pkg::STRIDE_WIDTH-1:0]   s;

      // after reset: raw, stride 1, no block start yet
      add_word_row(1'b0, 32'h0000_0000, 1'b1, 32'h0000_0000);
      add_word_row(1'b0, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
      add_word_row(1'b1, 32'h8000_0000, 1'b1, 32'h8000_0000);
      add_cfg_row(wdte_pkg::MODE_FIRST, 7'd1);
      add_word_row(1'b1, 32'h0000_0005, 1'b1, 32'h0000_0005);
      add_word_row(1'b0, 32'h0000_0003, 1'b1, 32'hFFFF_FFFE);
      add_word_row(1'b0, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFC);
      add_word_row(1'b0, 32'h0000_0000, 1'b1, 32'h0000_0001);
      // period zero acts as one
      add_cfg_row(wdte_pkg::MODE_STRIDE, 7'd0);
      add_word_row(1'b1, 32'h0000_000A, 1'b1, 32'h0000_000A);
      add_word_row(1'b0, 32'h0000_0007, 1'b1, 32'hFFFF_FFFD);
      add_cfg_row(wdte_pkg::MODE_STRIDE, 7'd2);
      add_word_row(1'b1, 32'd100, 1'b1, 32'd100);
      add_word_row(1'b0, 32'd200, 1'b1, 32'd200);
      add_word_row(1'b0, 32'd150, 1'b1, 32'd50);
      // period above the history depth saturates
      add_cfg_row(wdte_pkg::MODE_STRIDE, 7'd127);
      add_word_row(1'b1, 32'd1234, 1'b1, 32'd1234);
      add_word_row(1'b0, 32'd5678, 1'b1, 32'd5678);
      add_cfg_row(wdte_pkg::MODE_STRIDE, 7'd64);
      add_word_row(1'b1, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
      add_cfg_row(wdte_pkg::MODE_RESID, 7'd64);
      add_word_row(1'b1, 32'd10, 1'b1, 32'd10);
      add_word_row(1'b0, 32'd20, 1'b1, 32'd10);
      add_word_row(1'b0, 32'd0, 1'b1, 32'd10);
      add_word_row(1'b0, 32'hFFFF_FFFF, 1'b1, 32'h0000_000C);
      add_word_row(1'b0, 32'h0000_0003, 1'b0, 32'h0);
      add_word_row(1'b1, 32'h0000_0007, 1'b1, 32'h0000_0007);

      repeat (8) @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[r]) begin
         if (dir_rows[r].kind == ROW_CFG) begin
            drain_results();
            write_regs(dir_rows[r].mode, dir_rows[r].stride);
         end else begin
            send_word(dir_rows[r].bs, dir_rows[r].word, dir_rows[r].known, dir_rows[r].result);
         end
      end

      issued = 0;
      hold_used = 1'b0;
      while (issued < 750) begin
         drain_results();
         m = wdte_pkg::MODE_WIDTH'($urandom_range(3));
         case ($urandom_range(5))
            0: s = 7'd0;
            1: s = 7'd1;
            2: s = 7'd64;
            3: s = 7'd127;
            default: s = wdte_pkg::STRIDE_WIDTH'($urandom_range(64, 1));
         endcase
         write_regs(m, s);
         phase_len = $urandom_range(90, 40);
         n = 0;
         while (n < phase_len && issued < 750) begin
            blk = ($urandom_range(9) == 0) ? $urandom_range(90, 60) : $urandom_range(20, 1);
            if (!hold_used && issued >= 480) begin
               hold_used = 1'b1;
               blk = 40;
               hold_go = 1'b1;
            end
            if (blk > 750 - issued) blk = 750 - issued;
            bs = ($urandom_range(9) != 0);
            style = $urandom_range(3);
            base = $urandom;
            slope = ($urandom_range(3) == 0) ? $urandom : $urandom_range(2000) - 1000;
            for (int j = 0; j < blk; j++) begin
               case (style)
                  0: w = base + slope * j;
                  1: w = base + slope * j + $urandom_range(15);
                  2: w = $urandom;
                  default: begin
                     case ($urandom_range(3))
                        0: w = 32'h0000_0000;
                        1: w = 32'hFFFF_FFFF;
                        2: w = 32'h8000_0000;
                        default: w = 32'h7FFF_FFFF;
                     endcase
                  end
               endcase
               send_word((j == 0) ? bs : ($urandom_range(49) == 0), w, 1'b0, '0);
            end
            n += blk;
            issued += blk;
         end
      end

      drain_results();
      repeat (50) @(negedge clock);
      if (failures == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/wdte_pkg.sv
hdl/word_delta_transform_encoder_top.sv
bench/word_delta_transform_encoder_top_tb.sv
